### hdl/mtq_pkg.sv
// Shared types, constants and helpers for the min-tracking two-stack FIFO.
`timescale 1ns / 1ps

package mtq_pkg;

    localparam int DEPTH       = 1024;
    localparam int VALUE_WIDTH = 32;
    localparam int FIELD_W     = 32;
    localparam int COUNT_W     = 11;
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int AW          = $clog2(DEPTH);
    localparam int CMDQ_DEPTH  = 4;
    localparam int CMDQ_AW     = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CW     = $clog2(CMDQ_DEPTH + 1);

    typedef logic signed [VALUE_WIDTH-1:0] val_t;

    typedef enum logic [1:0] {
        OP_ENQ = 2'd0,
        OP_DEQ = 2'd1,
        OP_INS = 2'd2,
        OP_CLR = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_REFILL,
        BK_FETCH
    } bk_state_t;

    typedef struct packed {
        logic [1:0]                func;
        logic signed [FIELD_W-1:0] push_value;
    } in_beat_t;

    typedef struct packed {
        status_t                   status;
        logic signed [FIELD_W-1:0] front_value;
        logic signed [FIELD_W-1:0] min_value;
        logic [COUNT_W-1:0]        count;
    } out_beat_t;

    typedef struct packed {
        op_t  op;
        val_t value;
    } cmd_t;

    // out-stack entry: value and running minimum of it and everything below
    typedef struct packed {
        val_t val;
        val_t mn;
    } ent_t;

    function automatic val_t vmin(input val_t a, input val_t b);
        vmin = (a < b) ? a : b;
    endfunction

    function automatic logic signed [FIELD_W-1:0] to_field(input val_t v);
        to_field = FIELD_W'(v);
    endfunction

endpackage

### hdl/mtq_cmd_queue.sv
// Short command queue between the front end and the execution back end.
`timescale 1ns / 1ps

module mtq_cmd_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          wr_valid,
    output logic          wr_ready,
    input  mtq_pkg::cmd_t wr_cmd,
    output logic          rd_valid,
    input  logic          rd_pop,
    output mtq_pkg::cmd_t rd_cmd
);
    import mtq_pkg::*;

    cmd_t               slot_reg [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMDQ_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMDQ_CW-1:0] cnt_reg, cnt_next;
    logic               push, pop;

    assign wr_ready = (cnt_reg != CMDQ_CW'(CMDQ_DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_cmd   = slot_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_pop && rd_valid;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + CMDQ_AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + CMDQ_AW'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + CMDQ_CW'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - CMDQ_CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

### hdl/mtq_front.sv
// Front end: takes input beats, decodes the operation and trims the value.
`timescale 1ns / 1ps

module mtq_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  mtq_pkg::in_beat_t s_data,
    output logic             cmd_valid,
    input  logic             cmd_ready,
    output mtq_pkg::cmd_t    cmd
);
    import mtq_pkg::*;

    logic hold_vld_reg, hold_vld_next;
    cmd_t hold_reg;
    cmd_t decoded;

    always_comb begin
        decoded.op    = op_t'(s_data.func);
        // keep the low bits as a two's complement value
        decoded.value = s_data.push_value[VALUE_WIDTH-1:0];
    end

    assign s_ready   = !hold_vld_reg || cmd_ready;
    assign cmd_valid = hold_vld_reg;
    assign cmd       = hold_reg;

    always_comb begin
        hold_vld_next = hold_vld_reg;
        if (s_valid && s_ready) begin
            hold_vld_next = 1'b1;
        end else if (cmd_ready) begin
            hold_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_vld_reg <= 1'b0;
        end else begin
            hold_vld_reg <= hold_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            hold_reg <= decoded;
        end
    end

endmodule

### hdl/mtq_back.sv
// Back end: the two stacks, the out-stack's cached top, refill sequencer and result register.
`timescale 1ns / 1ps

module mtq_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cmd_valid,
    input  mtq_pkg::cmd_t      cmd,
    output logic               cmd_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output mtq_pkg::out_beat_t m_data
);
    import mtq_pkg::*;

    bk_state_t        state_reg, state_next;
    logic [CNT_W-1:0] in_cnt_reg, in_cnt_next;
    logic [CNT_W-1:0] out_cnt_reg, out_cnt_next;
    val_t             in_min_reg, in_min_next;
    val_t             top_val_reg, top_val_next;
    val_t             top_mn_reg, top_mn_next;
    val_t             front_reg, front_next;
    logic             rd_vld_reg, rd_vld_next;
    logic             m_valid_reg, m_valid_next;
    out_beat_t        m_data_reg, m_data_next;

    // stack memories; the in-stack only needs values, minima are rebuilt on refill
    val_t             in_mem  [DEPTH];
    ent_t             out_mem [DEPTH];
    val_t             in_rd_q;
    ent_t             out_rd_q;
    logic             in_we, out_we;
    logic [AW-1:0]    in_wa, in_ra, out_wa, out_ra;
    val_t             in_wd;
    ent_t             out_wd;

    logic [CNT_W-1:0] total, in_dec, out_dec, out_m2;
    logic             slot_free, is_empty, is_full, start, do_read;
    val_t             cur_min, enq_mn, fill_mn;

    assign total     = in_cnt_reg + out_cnt_reg;
    assign in_dec    = in_cnt_reg - CNT_W'(1);
    assign out_dec   = out_cnt_reg - CNT_W'(1);
    assign out_m2    = out_cnt_reg - CNT_W'(2);
    assign in_wa     = in_cnt_reg[AW-1:0];
    assign in_ra     = in_dec[AW-1:0];
    assign out_wa    = out_cnt_reg[AW-1:0];
    assign out_ra    = out_m2[AW-1:0];
    assign in_wd     = cmd.value;
    assign slot_free = !m_valid_reg || m_ready;
    assign is_empty  = (total == '0);
    assign is_full   = (total >= CNT_W'(DEPTH));
    assign start     = (state_reg == BK_IDLE) && cmd_valid && slot_free;
    assign do_read   = (cmd.op == OP_DEQ) || (cmd.op == OP_INS);
    assign enq_mn    = (in_cnt_reg != '0) ? vmin(cmd.value, in_min_reg) : cmd.value;
    assign fill_mn   = (out_cnt_reg != '0) ? vmin(in_rd_q, top_mn_reg) : in_rd_q;

    always_comb begin
        if (in_cnt_reg == '0 && out_cnt_reg == '0) begin
            cur_min = '0;
        end else if (in_cnt_reg == '0) begin
            cur_min = top_mn_reg;
        end else if (out_cnt_reg == '0) begin
            cur_min = in_min_reg;
        end else begin
            cur_min = vmin(in_min_reg, top_mn_reg);
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE: begin
                if (start && do_read && !is_empty) begin
                    if (out_cnt_reg == '0) begin
                        state_next = BK_REFILL;
                    end else if (cmd.op == OP_DEQ && out_cnt_reg > CNT_W'(1)) begin
                        state_next = BK_FETCH;
                    end
                end
            end
            BK_REFILL: begin
                if (in_cnt_reg == '0 && !rd_vld_reg) begin
                    state_next = BK_IDLE;
                end
            end
            BK_FETCH: begin
                state_next = BK_IDLE;
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        in_cnt_next  = in_cnt_reg;
        out_cnt_next = out_cnt_reg;
        in_min_next  = in_min_reg;
        top_val_next = top_val_reg;
        top_mn_next  = top_mn_reg;
        front_next   = front_reg;
        rd_vld_next  = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        in_we        = 1'b0;
        out_we       = 1'b0;
        out_wd.val   = in_rd_q;
        out_wd.mn    = fill_mn;
        cmd_pop      = 1'b0;

        case (state_reg)
            BK_IDLE: begin
                if (start) begin
                    m_data_next.status      = ST_OK;
                    m_data_next.front_value = '0;
                    m_data_next.min_value   = to_field(cur_min);
                    m_data_next.count       = COUNT_W'(total);
                    case (cmd.op)
                        OP_ENQ: begin
                            m_valid_next = 1'b1;
                            cmd_pop      = 1'b1;
                            if (is_full) begin
                                m_data_next.status = ST_FULL;
                            end else begin
                                in_we       = 1'b1;
                                in_min_next = enq_mn;
                                in_cnt_next = in_cnt_reg + CNT_W'(1);
                                m_data_next.min_value = to_field(
                                    (out_cnt_reg != '0) ? vmin(enq_mn, top_mn_reg) : enq_mn);
                                m_data_next.count = COUNT_W'(total + CNT_W'(1));
                            end
                        end
                        OP_CLR: begin
                            m_valid_next          = 1'b1;
                            cmd_pop               = 1'b1;
                            in_cnt_next           = '0;
                            out_cnt_next          = '0;
                            m_data_next.min_value = '0;
                            m_data_next.count     = '0;
                        end
                        OP_DEQ, OP_INS: begin
                            if (is_empty) begin
                                m_valid_next       = 1'b1;
                                cmd_pop            = 1'b1;
                                m_data_next.status = ST_EMPTY;
                            end else if (out_cnt_reg != '0) begin
                                m_data_next.front_value = to_field(top_val_reg);
                                if (cmd.op == OP_INS) begin
                                    m_valid_next = 1'b1;
                                    cmd_pop      = 1'b1;
                                end else begin
                                    out_cnt_next = out_dec;
                                    front_next   = top_val_reg;
                                    if (out_cnt_reg == CNT_W'(1)) begin
                                        // out-stack drains: only the in-stack is left
                                        m_valid_next = 1'b1;
                                        cmd_pop      = 1'b1;
                                        m_data_next.min_value = to_field(
                                            (in_cnt_reg != '0) ? in_min_reg : '0);
                                        m_data_next.count = COUNT_W'(total - CNT_W'(1));
                                    end
                                end
                            end
                        end
                        default: begin
                            cmd_pop = 1'b0;
                        end
                    endcase
                end
            end
            BK_REFILL: begin
                // pop the in-stack top while the previous read lands on the out-stack
                if (in_cnt_reg != '0) begin
                    in_cnt_next = in_dec;
                    rd_vld_next = 1'b1;
                end
                if (rd_vld_reg) begin
                    out_we       = 1'b1;
                    out_cnt_next = out_cnt_reg + CNT_W'(1);
                    top_val_next = in_rd_q;
                    top_mn_next  = fill_mn;
                end
            end
            BK_FETCH: begin
                top_val_next                 = out_rd_q.val;
                top_mn_next                  = out_rd_q.mn;
                m_valid_next                 = 1'b1;
                cmd_pop                      = 1'b1;
                m_data_next.status           = ST_OK;
                m_data_next.front_value      = to_field(front_reg);
                m_data_next.min_value        = to_field(
                    (in_cnt_reg != '0) ? vmin(in_min_reg, out_rd_q.mn) : out_rd_q.mn);
                m_data_next.count            = COUNT_W'(total);
            end
            default: begin
                rd_vld_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            in_cnt_reg  <= '0;
            out_cnt_reg <= '0;
            rd_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            in_cnt_reg  <= in_cnt_next;
            out_cnt_reg <= out_cnt_next;
            rd_vld_reg  <= rd_vld_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_min_reg  <= in_min_next;
        top_val_reg <= top_val_next;
        top_mn_reg  <= top_mn_next;
        front_reg   <= front_next;
        m_data_reg  <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (in_we) begin
            in_mem[in_wa] <= in_wd;
        end
        in_rd_q <= in_mem[in_ra];
    end

    always_ff @(posedge aclk) begin
        if (out_we) begin
            out_mem[out_wa] <= out_wd;
        end
        out_rd_q <= out_mem[out_ra];
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

### hdl/min_tracking_fifo_two_stacks_core.sv
// Top level of the min-tracking FIFO built from two stacks.
// Enqueue, inspect, clear and error results pass the front-end register, the command queue
// and the result register; a dequeue that leaves the out-stack non-empty also reloads the top.
// A dequeue or inspect on an empty out-stack first refills it from the in-stack.
// Throughput: one beat per cycle unless the result stalls; top reloads and refills hold it up.
// Reset clears counts, queue and handshake state; stack memories are not cleared.
`timescale 1ns / 1ps

module min_tracking_fifo_two_stacks_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  mtq_pkg::in_beat_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output mtq_pkg::out_beat_t m_data
);
    import mtq_pkg::*;

    logic fe_valid, fe_ready, q_valid, q_pop;
    cmd_t fe_cmd, q_cmd;

    mtq_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cmd_valid (fe_valid),
        .cmd_ready (fe_ready),
        .cmd       (fe_cmd)
    );

    mtq_cmd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (fe_valid),
        .wr_ready (fe_ready),
        .wr_cmd   (fe_cmd),
        .rd_valid (q_valid),
        .rd_pop   (q_pop),
        .rd_cmd   (q_cmd)
    );

    mtq_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (q_valid),
        .cmd       (q_cmd),
        .cmd_pop   (q_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

### hdl/mtq_checker.sv
// Port-level checks for the min-tracking FIFO, bound to the top level.
`timescale 1ns / 1ps

module mtq_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input mtq_pkg::in_beat_t  s_data,
    input logic               m_valid,
    input logic               m_ready,
    input mtq_pkg::out_beat_t m_data
);
    import mtq_pkg::*;

    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result beat valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result beat changed");

    a_empty_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == ST_EMPTY |->
            m_data.count == '0 && m_data.front_value == '0 && m_data.min_value == '0)
        else $error("empty error beat carries data");

    a_full_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == ST_FULL |->
            m_data.count == COUNT_W'(DEPTH) && m_data.front_value == '0)
        else $error("full error with wrong count");

    a_empty_min: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.count == '0 |-> m_data.min_value == '0)
        else $error("nonzero minimum on an empty queue");

endmodule

bind min_tracking_fifo_two_stacks_core mtq_checker u_mtq_checker (.*);
